@@ sv/lwqd_pkg.sv @@
// Shared widths, command, status and register codes of the dispatcher.
`default_nettype none
package lwqd_pkg;
  localparam int CMD_W   = 2;
  localparam int QID_W   = 3;
  localparam int TIME_W  = 32;
  localparam int ITEM_W  = 10;
  localparam int STAT_W  = 3;
  localparam int JCNT_W  = 7;
  localparam int JOB_W   = 21;
  localparam int UQ_W    = 6;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;

  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_PAST   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTQ   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOOPEN = 3'd4;

  localparam logic [CIDX_W-1:0] REG_ACTIVE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SCAN    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PAY     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_HORIZON = 2'd3;

  typedef logic [TIME_W-1:0] time_t;

  function automatic time_t sub_sat(input time_t a, input time_t b);
    sub_sat = (a > b) ? a - b : '0;
  endfunction

  function automatic time_t add_sat(input time_t a, input logic [JOB_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-JOB_W){1'b0}}, b};
    add_sat = s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/lwqd_if.sv @@
// Channel interfaces: command input, result output and register write.
`default_nettype none
interface lwqd_in_if;
  import lwqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QID_W-1:0]  queue_id;
  logic [TIME_W-1:0] gap;
  logic [ITEM_W-1:0] item_count;
  modport source (output valid, cmd, queue_id, gap, item_count, input ready);
  modport sink (input valid, cmd, queue_id, gap, item_count, output ready);
endinterface

interface lwqd_out_if;
  import lwqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [QID_W-1:0]  target_queue;
  logic              queue_open;
  logic [JCNT_W-1:0] job_count;
  logic [TIME_W-1:0] workload;
  modport source (output valid, status, target_queue, queue_open, job_count, workload,
                  input ready);
  modport sink (input valid, status, target_queue, queue_open, job_count, workload,
                output ready);
endinterface

interface lwqd_cfg_if;
  import lwqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/least_workload_queue_dispatcher.sv @@
// Least-workload dispatcher: queue state, job time memory and command sequencer.
//  channel | dir | word
//  in_ch   | in  | cmd, queue_id, gap, item_count
//  out_ch  | out | status, target_queue, queue_open, job_count, workload
//  cfg_ch  | in  | index, data (0 active_queues, 1 scan_time, 2 pay_time, 3 horizon)
// One command at a time; the job time memory has one read and one write port.
// An arrival drains every open queue in use by its gap, then picks the least-loaded one;
// one crossing the horizon skips the pick. Close of an open queue serves its head job
// and moves the rest, one by one, to the least-loaded open queue in use.
// rst_n is synchronous; job times need no clearing. Input stalls until the
// result word is taken.
`default_nettype none
module least_workload_queue_dispatcher #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  lwqd_in_if.sink     in_ch,
  lwqd_out_if.source  out_ch,
  lwqd_cfg_if.sink    cfg_ch
);
  import lwqd_pkg::*;

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = HW + 2;
  localparam int DEPTH = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_EMIT = 4'd1, S_DR_CHK = 4'd2,
    S_DR_EVAL = 4'd3, S_PICK = 4'd4, S_ARR_PUSH = 4'd5, S_CL_CHK = 4'd6,
    S_CL_EVAL = 4'd7, S_CL_PUSH = 4'd8;

  logic [3:0]        state_r;
  logic              open_r [MAX_QUEUES];
  logic [HW-1:0]     head_r [MAX_QUEUES];
  logic [CW-1:0]     cnt_r  [MAX_QUEUES];
  time_t             wl_r   [MAX_QUEUES];
  time_t             elapsed_r;
  logic [3:0]        active_r;
  logic [9:0]        scan_r, pay_r;
  time_t             horizon_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [QID_W-1:0]  q_r;
  time_t             gap_r, g_r, best_wl_r;
  logic              qit_r, found_r, first_r, show_r;
  logic [JOB_W-1:0]  job_r, t_r;
  logic [UQ_W-1:0]   idx_r;
  logic [QW-1:0]     best_r;
  logic [STAT_W-1:0] st_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [QID_W-1:0]  out_tgt_r;
  logic              out_open_r;
  logic [JCNT_W-1:0] out_cnt_r;
  time_t             out_wl_r;

  logic [JOB_W-1:0]  mem [DEPTH];
  logic [JOB_W-1:0]  rd_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [JOB_W-1:0]  wr_data;

  logic [UQ_W-1:0]   used;
  logic [QW-1:0]     ii, qi, qin;
  logic              in_acc;
  logic [TIME_W:0]   arr_sum;
  logic [JOB_W-1:0]  job_calc;
  logic [QW-1:0]     rq;

  function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] q,
                                            input logic [HW-1:0] s);
    addr_of = AW'(q * QUEUE_DEPTH) + AW'(s);
  endfunction

  function automatic logic [HW-1:0] tail_of(input logic [HW-1:0] h,
                                            input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    tail_of = HW'(s);
  endfunction

  function automatic logic [HW-1:0] inc_head(input logic [HW-1:0] h);
    inc_head = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  assign used = ({2'b0, active_r} < UQ_W'(MAX_QUEUES)) ? {2'b0, active_r}
                                                       : UQ_W'(MAX_QUEUES);
  assign ii  = QW'(idx_r);
  assign qi  = QW'(q_r);
  assign qin = QW'(in_ch.queue_id);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign arr_sum = {1'b0, elapsed_r} + {1'b0, in_ch.gap};
  assign job_calc = JOB_W'(in_ch.item_count) * JOB_W'(scan_r) + JOB_W'(pay_r);
  // the drain walk addresses the scanned queue while reading and trimming its head
  assign rq = (state_r == S_DR_CHK || state_r == S_DR_EVAL) ? ii : qi;
  assign rd_addr = addr_of(rq, head_r[rq]);

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.target_queue = out_tgt_r;
  assign out_ch.queue_open = out_open_r;
  assign out_ch.job_count = out_cnt_r;
  assign out_ch.workload = out_wl_r;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_addr;
    wr_data = rd_q;
    case (state_r)
      S_DR_EVAL: begin
        if ({{(TIME_W-JOB_W){1'b0}}, rd_q} > g_r) begin
          wr_en = 1'b1;
          wr_data = rd_q - g_r[JOB_W-1:0];
        end
      end
      S_ARR_PUSH: begin
        wr_en = qit_r && found_r && (cnt_r[best_r] < CW'(QUEUE_DEPTH));
        wr_addr = addr_of(best_r, tail_of(head_r[best_r], cnt_r[best_r]));
        wr_data = job_r;
      end
      S_CL_PUSH: begin
        wr_en = found_r && (cnt_r[best_r] < CW'(QUEUE_DEPTH));
        wr_addr = addr_of(best_r, tail_of(head_r[best_r], cnt_r[best_r]));
        wr_data = t_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r <= '0;
      active_r <= 4'd8;
      scan_r <= 10'd5;
      pay_r <= 10'd5;
      horizon_r <= '1;
      for (int k = 0; k < MAX_QUEUES; k++) begin
        open_r[k] <= 1'b0;
        head_r[k] <= '0;
        cnt_r[k] <= '0;
        wl_r[k] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ACTIVE:  active_r <= cfg_ch.data[3:0];
          REG_SCAN:    scan_r <= cfg_ch.data[9:0];
          REG_PAY:     pay_r <= cfg_ch.data[9:0];
          REG_HORIZON: horizon_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_ch.cmd;
            q_r <= in_ch.queue_id;
            job_r <= job_calc;
            st_r <= ST_OK;
            show_r <= 1'b1;
            state_r <= S_EMIT;
            if (in_ch.cmd == CMD_READ) begin
              st_r <= ST_OK;
            end else if (elapsed_r >= horizon_r) begin
              st_r <= ST_PAST;
              show_r <= (in_ch.cmd != CMD_ARR);
            end else if (in_ch.cmd == CMD_OPEN) begin
              if ({3'b0, in_ch.queue_id} < used) open_r[qin] <= 1'b1;
            end else if (in_ch.cmd == CMD_CLOSE) begin
              if ({3'b0, in_ch.queue_id} < used && open_r[qin]) begin
                open_r[qin] <= 1'b0;
                first_r <= 1'b1;
                state_r <= S_CL_CHK;
              end
            end else begin
              if (arr_sum > {1'b0, horizon_r}) begin
                gap_r <= horizon_r - elapsed_r;
                g_r <= horizon_r - elapsed_r;
                elapsed_r <= horizon_r;
                qit_r <= 1'b0;
              end else begin
                gap_r <= in_ch.gap;
                g_r <= in_ch.gap;
                elapsed_r <= arr_sum[TIME_W-1:0];
                qit_r <= 1'b1;
              end
              idx_r <= '0;
              state_r <= S_DR_CHK;
            end
          end
        end
        S_DR_CHK: begin
          if (idx_r >= used) begin
            idx_r <= '0;
            found_r <= 1'b0;
            if (!qit_r) begin
              st_r <= ST_NOTQ;
              q_r <= '0;
              show_r <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_PICK;
            end
          end else if (!open_r[ii]) begin
            idx_r <= idx_r + 1'b1;
          end else if (cnt_r[ii] != '0 && g_r != '0) begin
            state_r <= S_DR_EVAL;
          end else begin
            wl_r[ii] <= sub_sat(wl_r[ii], g_r);
            g_r <= gap_r;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DR_EVAL: begin
          if ({{(TIME_W-JOB_W){1'b0}}, rd_q} > g_r) begin
            // head outlasts the gap: trim it and move on
            wl_r[ii] <= sub_sat(wl_r[ii], g_r);
            g_r <= gap_r;
            idx_r <= idx_r + 1'b1;
          end else begin
            g_r <= g_r - {{(TIME_W-JOB_W){1'b0}}, rd_q};
            head_r[ii] <= inc_head(head_r[ii]);
            cnt_r[ii] <= cnt_r[ii] - 1'b1;
            wl_r[ii] <= sub_sat(wl_r[ii], {{(TIME_W-JOB_W){1'b0}}, rd_q});
          end
          state_r <= S_DR_CHK;
        end
        S_PICK: begin
          if (idx_r < used) begin
            if (open_r[ii] && (!found_r || wl_r[ii] < best_wl_r)) begin
              found_r <= 1'b1;
              best_r <= ii;
              best_wl_r <= wl_r[ii];
            end
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= (cmd_r == CMD_ARR) ? S_ARR_PUSH : S_CL_PUSH;
          end
        end
        S_ARR_PUSH: begin
          state_r <= S_EMIT;
          if (!found_r) begin
            st_r <= ST_NOOPEN;
            q_r <= '0;
            show_r <= 1'b0;
          end else begin
            q_r <= QID_W'(best_r);
            if (cnt_r[best_r] >= CW'(QUEUE_DEPTH)) begin
              st_r <= ST_FULL;
            end else begin
              cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
              wl_r[best_r] <= add_sat(wl_r[best_r], job_r);
            end
          end
        end
        S_CL_CHK: begin
          state_r <= (cnt_r[qi] != '0) ? S_CL_EVAL : S_EMIT;
        end
        S_CL_EVAL: begin
          head_r[qi] <= inc_head(head_r[qi]);
          cnt_r[qi] <= cnt_r[qi] - 1'b1;
          wl_r[qi] <= sub_sat(wl_r[qi], {{(TIME_W-JOB_W){1'b0}}, rd_q});
          t_r <= rd_q;
          idx_r <= '0;
          found_r <= 1'b0;
          if (first_r) begin
            // head job is served on close, not moved
            first_r <= 1'b0;
            state_r <= S_CL_CHK;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_CL_PUSH: begin
          if (!found_r) begin
            st_r <= ST_NOOPEN;
          end else if (cnt_r[best_r] >= CW'(QUEUE_DEPTH)) begin
            if (st_r == ST_OK) st_r <= ST_FULL;
          end else begin
            cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
            wl_r[best_r] <= add_sat(wl_r[best_r], t_r);
          end
          state_r <= S_CL_CHK;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          out_status_r <= st_r;
          out_tgt_r <= q_r;
          if (show_r && {3'b0, q_r} < UQ_W'(MAX_QUEUES)) begin
            out_open_r <= open_r[qi];
            out_cnt_r <= JCNT_W'(cnt_r[qi]);
            out_wl_r <= wl_r[qi];
          end else begin
            out_open_r <= 1'b0;
            out_cnt_r <= '0;
            out_wl_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("accepted word did not start work");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_valid_r) else $error("input taken while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(QUEUE_DEPTH)) else $error("queue 0 count past depth");
  a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |=> out_valid_r) else $error("result not presented");
`endif
endmodule
`default_nettype wire

@@ tb/sv/least_workload_queue_dispatcher_tb.sv @@
// Self-checking testbench of the least-workload queue dispatcher.
`timescale 1ns / 1ps
module least_workload_queue_dispatcher_tb;
  import lwqd_pkg::*;

  localparam int NQ = 8;
  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [QID_W-1:0]  target_queue;
    logic              queue_open;
    logic [JCNT_W-1:0] job_count;
    logic [TIME_W-1:0] workload;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [QID_W-1:0]  qid;
    logic [TIME_W-1:0] gap;
    logic [ITEM_W-1:0] items;
    bit                typed;
    result_t           want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lwqd_in_if  in_ch ();
  lwqd_out_if out_ch ();
  lwqd_cfg_if cfg_ch ();

  least_workload_queue_dispatcher u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state of the dispatcher
  bit                q_open [NQ];
  logic [JOB_W-1:0]  q_jobs [NQ][$];
  logic [TIME_W-1:0] q_load [NQ];
  logic [TIME_W-1:0] elapsed;
  logic [3:0]        r_active;
  logic [9:0]        r_scan;
  logic [9:0]        r_pay;
  logic [TIME_W-1:0] r_horizon;

  result_t pending_results[$];
  int      fails = 0;
  int      sent = 0;
  int      stall_cnt = 0;
  bit      big_gaps = 1'b0;

  function automatic int used_count();
    return (r_active < NQ) ? r_active : NQ;
  endfunction

  function automatic logic [JOB_W-1:0] take_head(int q);
    logic [JOB_W-1:0] t;
    t = q_jobs[q].pop_front();
    q_load[q] = (q_load[q] > t) ? q_load[q] - t : '0;
    return t;
  endfunction

  function automatic bit put_job(int q, logic [JOB_W-1:0] t);
    logic [TIME_W:0] s;
    if (q_jobs[q].size() >= DEPTH) return 1'b0;
    q_jobs[q].push_back(t);
    s = {1'b0, q_load[q]} + t;
    q_load[q] = s[TIME_W] ? '1 : s[TIME_W-1:0];
    return 1'b1;
  endfunction

  function automatic int least_loaded();
    int best;
    best = -1;
    for (int i = 0; i < used_count(); i++)
      if (q_open[i] && (best < 0 || q_load[i] < q_load[best])) best = i;
    return best;
  endfunction

  function automatic result_t show(logic [STAT_W-1:0] st, int q, bit full);
    result_t r;
    r = '0;
    r.status = st;
    r.target_queue = q[QID_W-1:0];
    if (full) begin
      r.queue_open = q_open[q];
      r.job_count = JCNT_W'(q_jobs[q].size());
      r.workload = q_load[q];
    end
    return r;
  endfunction

  function automatic result_t dispatch(logic [CMD_W-1:0] cmd, logic [QID_W-1:0] qid,
                                       logic [TIME_W-1:0] gap, logic [ITEM_W-1:0] items);
    int n, q, d;
    logic [STAT_W-1:0] st;
    logic [TIME_W-1:0] g;
    logic [TIME_W-1:0] t;
    bit queue_it;
    n = used_count();
    q = qid;
    if (cmd == CMD_READ) return show(ST_OK, q, 1'b1);
    if (elapsed >= r_horizon) return show(ST_PAST, q, cmd != CMD_ARR);
    if (cmd == CMD_OPEN) begin
      if (q < n) q_open[q] = 1'b1;
      return show(ST_OK, q, 1'b1);
    end
    if (cmd == CMD_CLOSE) begin
      st = ST_OK;
      if (q < n && q_open[q]) begin
        if (q_jobs[q].size() > 0) void'(take_head(q));
        q_open[q] = 1'b0;
        while (q_jobs[q].size() > 0) begin
          t = TIME_W'(take_head(q));
          d = least_loaded();
          if (d < 0) st = ST_NOOPEN;
          else if (!put_job(d, t[JOB_W-1:0]) && st == ST_OK) st = ST_FULL;
        end
      end
      return show(st, q, 1'b1);
    end
    queue_it = 1'b1;
    if ({1'b0, elapsed} + gap > {1'b0, r_horizon}) begin
      gap = r_horizon - elapsed;
      queue_it = 1'b0;
    end
    elapsed += gap;
    for (int i = 0; i < n; i++) begin
      if (!q_open[i]) continue;
      g = gap;
      while (q_jobs[i].size() > 0 && g > 0) begin
        if (q_jobs[i][0] > g) begin
          q_jobs[i][0] = q_jobs[i][0] - g[JOB_W-1:0];
          break;
        end
        g -= q_jobs[i][0];
        void'(take_head(i));
      end
      q_load[i] = (q_load[i] > g) ? q_load[i] - g : '0;
    end
    if (!queue_it) return show(ST_NOTQ, 0, 1'b0);
    d = least_loaded();
    if (d < 0) return show(ST_NOOPEN, 0, 1'b0);
    t = items * r_scan + r_pay;
    if (!put_job(d, t[JOB_W-1:0])) return show(ST_FULL, d, 1'b1);
    return show(ST_OK, d, 1'b1);
  endfunction

  function automatic bit may_idle();
    return !(sent >= 500 && sent < 700) && ($urandom_range(99) < 12);
  endfunction

  // drive one command word and wait for its handshake
  task automatic send_word(row_t r);
    result_t res;
    while (may_idle()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= r.cmd;
    in_ch.queue_id <= r.qid;
    in_ch.gap <= r.gap;
    in_ch.item_count <= r.items;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    res = dispatch(r.cmd, r.qid, r.gap, r.items);
    pending_results.push_back(r.typed ? r.want : res);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // valid is left high between back-to-back writes; the caller drops it
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    case (idx)
      REG_ACTIVE:  r_active = val[3:0];
      REG_SCAN:    r_scan = val[9:0];
      REG_PAY:     r_pay = val[9:0];
      REG_HORIZON: r_horizon = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [3:0] act, logic [9:0] sc, logic [9:0] py,
                          logic [TIME_W-1:0] hz);
    drain_results();
    write_reg(REG_ACTIVE, CDAT_W'(act));
    write_reg(REG_SCAN, CDAT_W'(sc));
    write_reg(REG_PAY, CDAT_W'(py));
    write_reg(REG_HORIZON, hz);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_words(int count, int gap_zero_pct);
    row_t r;
    int pick;
    for (int k = 0; k < count; k++) begin
      r.typed = 1'b0;
      r.want = '0;
      pick = $urandom_range(99);
      if (pick < 25) r.cmd = CMD_OPEN;
      else if (pick < 35) r.cmd = CMD_CLOSE;
      else if (pick < 80) r.cmd = CMD_ARR;
      else r.cmd = CMD_READ;
      r.qid = QID_W'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < gap_zero_pct) r.gap = '0;
      else if (big_gaps && pick < gap_zero_pct + 15) r.gap = $urandom;
      else if (pick < 80) r.gap = $urandom_range(400);
      else r.gap = $urandom_range(20000);
      pick = $urandom_range(9);
      r.items = (pick == 0) ? 10'h3ff : (pick == 1) ? 10'h0 : 10'($urandom);
      send_word(r);
    end
  endtask

  row_t directed[$];

  function automatic row_t mk(logic [CMD_W-1:0] c, logic [QID_W-1:0] q,
                              logic [TIME_W-1:0] g, logic [ITEM_W-1:0] it);
    row_t r;
    r.cmd = c;
    r.qid = q;
    r.gap = g;
    r.items = it;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_typed(logic [CMD_W-1:0] c, logic [QID_W-1:0] q,
                                    logic [TIME_W-1:0] g, logic [ITEM_W-1:0] it,
                                    result_t w);
    row_t r;
    r = mk(c, q, g, it);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_READ;
    in_ch.queue_id = '0;
    in_ch.gap = '0;
    in_ch.item_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ACTIVE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    elapsed = '0;
    r_active = 4'd8;
    r_scan = 10'd5;
    r_pay = 10'd5;
    r_horizon = '1;
    for (int i = 0; i < NQ; i++) begin
      q_open[i] = 1'b0;
      q_load[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_typed(CMD_READ, 0, 0, 0, '{ST_OK, 3'd0, 1'b0, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_ARR, 5, 5, 3, '{ST_NOOPEN, 3'd0, 1'b0, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_OPEN, 0, 0, 0, '{ST_OK, 3'd0, 1'b1, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_OPEN, 7, 0, 0, '{ST_OK, 3'd7, 1'b1, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_OPEN, 7, 0, 0, '{ST_OK, 3'd7, 1'b1, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_CLOSE, 7, 0, 0, '{ST_OK, 3'd7, 1'b0, 7'd0, 32'd0}));
    directed.push_back(mk_typed(CMD_CLOSE, 7, 0, 0, '{ST_OK, 3'd7, 1'b0, 7'd0, 32'd0}));
    directed.push_back(mk(CMD_ARR, 0, 0, 10'h3ff));
    directed.push_back(mk(CMD_ARR, 0, 0, 10'h0));
    directed.push_back(mk(CMD_OPEN, 1, 0, 0));
    directed.push_back(mk(CMD_ARR, 0, 7, 2));
    directed.push_back(mk(CMD_ARR, 0, 3, 1000));
    directed.push_back(mk(CMD_ARR, 0, 0, 500));
    directed.push_back(mk(CMD_READ, 0, 0, 0));
    directed.push_back(mk(CMD_CLOSE, 0, 0, 0));
    directed.push_back(mk(CMD_READ, 1, 0, 0));
    directed.push_back(mk(CMD_ARR, 0, 5000, 1));
    directed.push_back(mk(CMD_CLOSE, 1, 0, 0));
    directed.push_back(mk(CMD_ARR, 0, 1, 1));
    directed.push_back(mk(CMD_READ, 7, 0, 0));
    foreach (directed[i]) send_word(directed[i]);

    set_regs(4'd8, 10'd5, 10'd5, '1);
    random_words(300, 20);
    // one queue in use and mostly zero gaps: push it into the full case
    set_regs(4'd1, 10'd0, 10'd1023, '1);
    random_words(200, 90);
    set_regs(4'd15, 10'd1023, 10'd0, '1);
    random_words(250, 30);
    set_regs(4'd0, 10'd7, 10'd3, '1);
    random_words(50, 20);
    drain_results();
    set_regs(4'd5, 10'($urandom), 10'($urandom), elapsed + 32'd20000);
    random_words(150, 10);
    set_regs(4'd8, 10'd5, 10'd5, '1);
    big_gaps = 1'b1;
    random_words(200, 20);
    set_regs(4'd3, 10'd1, 10'd1, '0);
    random_words(50, 20);

    drain_results();
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // result side: random backpressure, check each word while valid and ready are both high
  always @(posedge clk) begin
    out_ch.ready <= !may_idle();
  end

  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fails++;
        end
        if (out_ch.target_queue !== want.target_queue) begin
          $error("target_queue: expected %0d, got %0d", want.target_queue,
                 out_ch.target_queue);
          fails++;
        end
        if (out_ch.queue_open !== want.queue_open) begin
          $error("queue_open: expected %0d, got %0d", want.queue_open, out_ch.queue_open);
          fails++;
        end
        if (out_ch.job_count !== want.job_count) begin
          $error("job_count: expected %0d, got %0d", want.job_count, out_ch.job_count);
          fails++;
        end
        if (out_ch.workload !== want.workload) begin
          $error("workload: expected %0d, got %0d", want.workload, out_ch.workload);
          fails++;
        end
      end
    end
  end

  // watchdog: count cycles with no handshake on any channel
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end
endmodule
